FILE: hw/rtl/lcbp_pkg.sv
// Shared types, constants and the control-store program for the balance-point block.
// No dependencies. Imported by load_cell_balance_point.
`timescale 1ns / 1ps
`default_nettype none

package lcbp_pkg;

    localparam int LOAD_W   = 24;               // stored reading width
    localparam int ID_W     = 63;
    localparam int ARM_W    = 16;
    localparam int TOTAL_W  = 26;
    localparam int PAIR_W   = LOAD_W + 1;       // l0+l2, l0-l2
    localparam int MUL_B_W  = ARM_W + 1;        // arm as signed operand
    localparam int ACC_W    = PAIR_W + MUL_B_W; // 42
    localparam int NUM_W    = ACC_W + 8;        // numerator scaled by 256
    localparam int QUO_W    = 32;
    localparam int DEN_W    = TOTAL_W;
    localparam int CNT_W    = 5;
    localparam int PC_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W     = 88;
    localparam int OUT_W    = 168;

    localparam logic [ID_W-1:0] RESET_ID_ZERO = 63'd342628709630718180;
    localparam logic [ID_W-1:0] RESET_ID_ONE  = 63'd3226339846031388900;
    localparam logic [ID_W-1:0] RESET_ID_TWO  = 63'd342628709630718170;
    localparam logic [1:0]      RESET_COUNT   = 2'd3;
    localparam logic [1:0]      TWO_CELLS     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_ZERO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ID_ONE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ID_TWO     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_FRONT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_REAR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_SIDE   = 3'd6;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_SUMS,
        OP_MUL_FRONT,
        OP_MUL_REAR,
        OP_MUL_SIDE,
        OP_DIV_LOAD_BAL,
        OP_DIV_LOAD_SIDE,
        OP_DIV_STEP,
        OP_STORE_BAL,
        OP_STORE_SIDE,
        OP_EMIT,
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_NO_ACCEPT,
        JC_TOTAL_ZERO,
        JC_TWO_MODE,
        JC_FRONT_ZERO,
        JC_DIV_MORE,
        JC_OUT_BUSY
    } jc_t;

    typedef struct packed {
        op_t             op;
        jc_t             jc;
        logic [PC_W-1:0] target;
    } ucode_t;

    localparam logic [PC_W-1:0] ST_IDLE       = 4'd0;
    localparam logic [PC_W-1:0] ST_SUMS       = 4'd1;
    localparam logic [PC_W-1:0] ST_MUL_FRONT  = 4'd2;
    localparam logic [PC_W-1:0] ST_MUL_REAR   = 4'd3;
    localparam logic [PC_W-1:0] ST_LOAD_BAL   = 4'd4;
    localparam logic [PC_W-1:0] ST_DIV_BAL    = 4'd5;
    localparam logic [PC_W-1:0] ST_STORE_BAL  = 4'd6;
    localparam logic [PC_W-1:0] ST_MUL_SIDE   = 4'd7;
    localparam logic [PC_W-1:0] ST_LOAD_SIDE  = 4'd8;
    localparam logic [PC_W-1:0] ST_DIV_SIDE   = 4'd9;
    localparam logic [PC_W-1:0] ST_STORE_SIDE = 4'd10;
    localparam logic [PC_W-1:0] ST_EMIT       = 4'd11;
    localparam logic [PC_W-1:0] ST_RETURN     = 4'd12;

    // control store: a taken jump goes to target, otherwise to the next step
    function automatic ucode_t lcbp_ucode(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            ST_IDLE:       w = '{OP_IDLE,          JC_NO_ACCEPT,  ST_IDLE};
            ST_SUMS:       w = '{OP_SUMS,          JC_NEXT,       ST_IDLE};
            ST_MUL_FRONT:  w = '{OP_MUL_FRONT,     JC_NEXT,       ST_IDLE};
            ST_MUL_REAR:   w = '{OP_MUL_REAR,      JC_TOTAL_ZERO, ST_MUL_SIDE};
            ST_LOAD_BAL:   w = '{OP_DIV_LOAD_BAL,  JC_NEXT,       ST_IDLE};
            ST_DIV_BAL:    w = '{OP_DIV_STEP,      JC_DIV_MORE,   ST_DIV_BAL};
            ST_STORE_BAL:  w = '{OP_STORE_BAL,     JC_NEXT,       ST_IDLE};
            ST_MUL_SIDE:   w = '{OP_MUL_SIDE,      JC_TWO_MODE,   ST_EMIT};
            ST_LOAD_SIDE:  w = '{OP_DIV_LOAD_SIDE, JC_FRONT_ZERO, ST_EMIT};
            ST_DIV_SIDE:   w = '{OP_DIV_STEP,      JC_DIV_MORE,   ST_DIV_SIDE};
            ST_STORE_SIDE: w = '{OP_STORE_SIDE,    JC_NEXT,       ST_IDLE};
            ST_EMIT:       w = '{OP_EMIT,          JC_OUT_BUSY,   ST_EMIT};
            ST_RETURN:     w = '{OP_NONE,          JC_ALWAYS,     ST_IDLE};
            default:       w = '{OP_NONE,          JC_ALWAYS,     ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/load_cell_balance_point.sv
// Load-cell balance point: stores cell readings by identifier and computes total
// weight, longitudinal balance point and lateral side difference. Uses lcbp_pkg.
//
// Channels: s_ carries one reading per beat (identifier and signed reading); m_
// returns one result beat per input beat. Configuration is a plain write port
// (cfg_wr_en, cfg_index, cfg_data) and must only be written while idle.
// Control is a microprogram in a small ROM: a step counter walks control words
// that drive one 25x17 multiplier-accumulator and one restoring divider that
// retires one quotient bit per cycle.
// In three-cell mode a beat passes through two 32-step divisions, in two-cell mode
// through one; a division is skipped when its divisor is zero. After the emit step
// the sequencer passes through a return step to the idle step, where the next beat
// is accepted.
// Reset (aresetn low, synchronous) restores register defaults, clears the stored
// loads and drops m_tvalid.
// When the receiver stalls, the result waits in the output register; the block
// still accepts and processes the next beat, then holds at the emit step until
// the output register is free. s_tready is high only at the idle step.
`timescale 1ns / 1ps
`default_nettype none

module load_cell_balance_point
    import lcbp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [62:0] unit_id, [86:63] reading, [87] zero
    input  wire logic [IN_W-1:0]      s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [25:0] total_weight, [57:26] balance_point, [58] balance_valid,
    // [90:59] side_difference, [91] side_valid, [92] matched,
    // [116:93] load_zero, [140:117] load_one, [164:141] load_two, [167:165] zero
    output logic [OUT_W-1:0]          m_tdata,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ID_W-1:0]      cfg_data
);

    // configuration
    logic [1:0]       count_reg;
    logic [ID_W-1:0]  id0_reg, id1_reg, id2_reg;
    logic [ARM_W-1:0] arm_front_reg, arm_rear_reg, arm_side_reg;

    // sequencer and datapath
    logic [PC_W-1:0]           pc_reg, pc_next;
    ucode_t                    uc;
    logic                      jump;
    logic signed [LOAD_W-1:0]  load0_reg, load1_reg, load2_reg;
    logic                      match_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic signed [PAIR_W-1:0]  sum02_reg, diff_reg;
    logic                      bv_reg, sv_reg;
    logic signed [QUO_W-1:0]   bp_reg, sd_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PAIR_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ACC_W-1:0]   product;

    // divider
    logic [DEN_W-1:0]   rem_reg, den_reg;
    logic [QUO_W-1:0]   dlow_reg, quo_reg;
    logic               neg_reg, ovf_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [NUM_W-1:0]  dividend;
    logic [NUM_W-1:0]         num_mag;
    logic signed [DEN_W-1:0]  den_src;
    logic [DEN_W-1:0]         den_mag;
    logic [DEN_W+1:0]         trial;
    logic [QUO_W-1:0]         sat_q;

    // output register
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic               out_free;

    logic                     two_mode;
    logic                     accept;
    logic [ID_W-1:0]          in_id;
    logic signed [LOAD_W-1:0] in_rd;
    logic signed [TOTAL_W-1:0] total_calc;
    logic signed [PAIR_W-1:0]  sum02_calc;

    assign uc       = lcbp_ucode(pc_reg);
    assign two_mode = (count_reg == TWO_CELLS);
    assign s_tready = (uc.op == OP_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_id    = s_tdata[ID_W-1:0];
    assign in_rd    = s_tdata[ID_W+LOAD_W-1:ID_W];
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign sum02_calc = PAIR_W'(load0_reg) + PAIR_W'(load2_reg);
    assign total_calc = two_mode ? (TOTAL_W'(load0_reg) + TOTAL_W'(load1_reg))
                                 : (TOTAL_W'(sum02_calc) + TOTAL_W'(load1_reg));

    always_comb begin
        case (uc.jc)
            JC_NEXT:       jump = 1'b0;
            JC_ALWAYS:     jump = 1'b1;
            JC_NO_ACCEPT:  jump = !accept;
            JC_TOTAL_ZERO: jump = !bv_reg;
            JC_TWO_MODE:   jump = two_mode;
            JC_FRONT_ZERO: jump = (sum02_reg == '0);
            JC_DIV_MORE:   jump = (cnt_reg != '0);
            JC_OUT_BUSY:   jump = !out_free;
            default:       jump = 1'b0;
        endcase
        pc_next = jump ? uc.target : pc_reg + PC_W'(1);
    end

    // shared multiplier operands
    always_comb begin
        case (uc.op)
            OP_MUL_FRONT: begin
                mul_a = two_mode ? PAIR_W'(load0_reg) : sum02_reg;
                mul_b = $signed({1'b0, arm_front_reg});
            end
            OP_MUL_REAR: begin
                mul_a = PAIR_W'(load1_reg);
                mul_b = $signed({1'b0, arm_rear_reg});
            end
            default: begin
                mul_a = diff_reg;
                mul_b = $signed({1'b0, arm_side_reg});
            end
        endcase
        product = ACC_W'(mul_a) * ACC_W'(mul_b);
    end

    // divider operand conditioning and one restoring step
    always_comb begin
        dividend = {acc_reg, 8'd0};
        num_mag  = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
        den_src  = (uc.op == OP_DIV_LOAD_SIDE) ? DEN_W'(sum02_reg) : total_reg;
        den_mag  = den_src[DEN_W-1] ? DEN_W'(-den_src) : DEN_W'(den_src);
        trial    = {1'b0, rem_reg, dlow_reg[QUO_W-1]} - {2'b00, den_reg};
        if (ovf_reg) begin
            sat_q = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (neg_reg) begin
            sat_q = (quo_reg > 32'h8000_0000) ? 32'h8000_0000 : (-quo_reg);
        end else begin
            sat_q = quo_reg[QUO_W-1] ? 32'h7FFF_FFFF : quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= ST_IDLE;
            count_reg     <= RESET_COUNT;
            id0_reg       <= RESET_ID_ZERO;
            id1_reg       <= RESET_ID_ONE;
            id2_reg       <= RESET_ID_TWO;
            arm_front_reg <= '0;
            arm_rear_reg  <= '0;
            arm_side_reg  <= '0;
            load0_reg     <= '0;
            load1_reg     <= '0;
            load2_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            pc_reg <= pc_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CELL_COUNT: count_reg     <= cfg_data[1:0];
                    REG_ID_ZERO:    id0_reg       <= cfg_data;
                    REG_ID_ONE:     id1_reg       <= cfg_data;
                    REG_ID_TWO:     id2_reg       <= cfg_data;
                    REG_ARM_FRONT:  arm_front_reg <= cfg_data[ARM_W-1:0];
                    REG_ARM_REAR:   arm_rear_reg  <= cfg_data[ARM_W-1:0];
                    REG_ARM_SIDE:   arm_side_reg  <= cfg_data[ARM_W-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                if (in_id == id0_reg) load0_reg <= in_rd;
                if (in_id == id1_reg) load1_reg <= in_rd;
                if (in_id == id2_reg) load2_reg <= in_rd;
                match_reg <= (in_id == id0_reg) || (in_id == id1_reg) ||
                             (in_id == id2_reg);
            end

            case (uc.op)
                OP_SUMS: begin
                    total_reg <= total_calc;
                    sum02_reg <= sum02_calc;
                    diff_reg  <= PAIR_W'(load0_reg) - PAIR_W'(load2_reg);
                    bv_reg    <= (total_calc != '0);
                    sv_reg    <= two_mode || (sum02_calc != '0);
                    bp_reg    <= '0;
                    sd_reg    <= '0;
                end
                OP_MUL_FRONT, OP_MUL_SIDE: acc_reg <= product;
                OP_MUL_REAR:               acc_reg <= acc_reg + product;
                OP_DIV_LOAD_BAL, OP_DIV_LOAD_SIDE: begin
                    den_reg  <= den_mag;
                    neg_reg  <= dividend[NUM_W-1] ^ den_src[DEN_W-1];
                    // quotient of 2^32 or more saturates either way
                    ovf_reg  <= DEN_W'(num_mag[NUM_W-1:QUO_W]) >= den_mag;
                    rem_reg  <= DEN_W'(num_mag[NUM_W-1:QUO_W]);
                    dlow_reg <= num_mag[QUO_W-1:0];
                    cnt_reg  <= CNT_W'(QUO_W - 1);
                end
                OP_DIV_STEP: begin
                    if (!trial[DEN_W+1]) begin
                        rem_reg <= trial[DEN_W-1:0];
                    end else begin
                        rem_reg <= {rem_reg[DEN_W-2:0], dlow_reg[QUO_W-1]};
                    end
                    quo_reg  <= {quo_reg[QUO_W-2:0], !trial[DEN_W+1]};
                    dlow_reg <= {dlow_reg[QUO_W-2:0], 1'b0};
                    cnt_reg  <= cnt_reg - CNT_W'(1);
                end
                OP_STORE_BAL:  bp_reg <= sat_q;
                OP_STORE_SIDE: sd_reg <= sat_q;
                default: ;
            endcase

            if (uc.op == OP_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {3'd0, load2_reg, load1_reg, load0_reg, match_reg,
                                  sv_reg, sd_reg, bv_reg, bp_reg, total_reg};
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // each divide step retires exactly one count
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (uc.op == OP_DIV_STEP && cnt_reg != '0) |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("divider step count did not advance");

    // an accepted beat always starts the sum step next
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (pc_reg == ST_SUMS))
        else $error("sequencer did not start after accept");

    // a zero total leaves the balance point at zero
    a_bp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_data_reg[58]) |-> (out_data_reg[57:26] == '0))
        else $error("balance point nonzero with invalid flag");

    // no result is overwritten while it waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> $stable(out_data_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
